@@ hw/rtl/gsfp_pkg.sv @@
// shared types, character codes and field numbering for the gga sentence parser
package gsfp_pkg;

    // fraction digit counter and scale count width (covers up to seven digits)
    localparam int FRAC_CNT_W = 3;

    // number of fixed point values kept per sentence
    localparam int NUM_FIXED = 7;

    // character codes
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SOUTH = 8'h53;
    localparam logic [7:0] CHAR_WEST  = 8'h57;

    // field numbers by comma count
    localparam logic [3:0] FLD_TIME    = 4'd1;
    localparam logic [3:0] FLD_LAT     = 4'd2;
    localparam logic [3:0] FLD_NS      = 4'd3;
    localparam logic [3:0] FLD_LON     = 4'd4;
    localparam logic [3:0] FLD_EW      = 4'd5;
    localparam logic [3:0] FLD_FIX     = 4'd6;
    localparam logic [3:0] FLD_SATS    = 4'd7;
    localparam logic [3:0] FLD_HDOP    = 4'd8;
    localparam logic [3:0] FLD_ALT     = 4'd9;
    localparam logic [3:0] FLD_GEOID   = 4'd11;
    localparam logic [3:0] FLD_AGE     = 4'd13;
    localparam logic [3:0] FLD_STATION = 4'd14;
    localparam logic [3:0] FLD_IDLE    = 4'd15;

    // slots of the fixed point value bank
    typedef logic [2:0] slot_t;
    localparam slot_t SLOT_LAT     = 3'd0;
    localparam slot_t SLOT_LON     = 3'd1;
    localparam slot_t SLOT_HDOP    = 3'd2;
    localparam slot_t SLOT_ALT     = 3'd3;
    localparam slot_t SLOT_GEOID   = 3'd4;
    localparam slot_t SLOT_AGE     = 3'd5;
    localparam slot_t SLOT_STATION = 3'd6;

    // integer limits
    localparam logic [23:0] UTC_MAX  = 24'hFF_FFFF;
    localparam logic [7:0]  SATS_MAX = 8'hFF;
    localparam logic [2:0]  FIX_MAX  = 3'd4;

    // commit operations handed from front to back
    typedef enum logic [2:0] {
        CMT_NONE,
        CMT_FIXED,
        CMT_UTC,
        CMT_NEGATE,
        CMT_FIX,
        CMT_SATS
    } cmt_op_t;

    // one queued command: optional clear, a field commit, an empty field commit, emit
    typedef struct packed {
        logic                  clear;
        cmt_op_t               a_op;
        slot_t                 a_slot;
        logic                  a_minus;
        logic [FRAC_CNT_W-1:0] a_scale;
        cmt_op_t               b_op;
        slot_t                 b_slot;
        logic                  emit;
    } cmd_t;

    typedef struct packed {
        logic  hit;
        slot_t slot;
    } slot_map_t;

    // fixed point field lookup
    function automatic slot_map_t fixed_slot(input logic [3:0] idx);
        slot_map_t r;
        r.hit  = 1'b1;
        r.slot = SLOT_LAT;
        unique case (idx)
            FLD_LAT:     r.slot = SLOT_LAT;
            FLD_LON:     r.slot = SLOT_LON;
            FLD_HDOP:    r.slot = SLOT_HDOP;
            FLD_ALT:     r.slot = SLOT_ALT;
            FLD_GEOID:   r.slot = SLOT_GEOID;
            FLD_AGE:     r.slot = SLOT_AGE;
            FLD_STATION: r.slot = SLOT_STATION;
            default:     r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/gga_sentence_field_parser_top.sv @@
// gga sentence field parser: front end, command queue and commit back end
// Throughput: one character per cycle while the command queue has room, limited by
//   the front end's single multiply-by-ten accumulate per character.
// The last character's command passes the queue, the stage registers (one decimal
//   scaling step per fraction digit) and the result register to form the record.
// Reset clears field state, kept values and fix code (no fix); no clearing pass.
module gga_sentence_field_parser_top #(
    parameter int VALUE_WIDTH = 40,
    parameter int FRAC_DIGITS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         ch,
    input  logic               first_char,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [23:0]        utc_time,
    output logic signed [39:0] latitude,
    output logic signed [39:0] longitude,
    output logic [2:0]         fix_code,
    output logic [7:0]         satellites,
    output logic signed [39:0] hdop,
    output logic signed [39:0] altitude,
    output logic signed [39:0] geoid_separation,
    output logic signed [39:0] dgps_age,
    output logic signed [39:0] station_id
);
    import gsfp_pkg::*;

    localparam int MW          = VALUE_WIDTH - 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QW          = $bits(cmd_t) + MW;

    logic          q_push;
    cmd_t          q_push_cmd;
    logic [MW-1:0] q_push_mag;
    logic          q_pop;
    logic [QW-1:0] q_head;
    logic          q_full;
    logic          q_empty;
    cmd_t          q_head_cmd;
    logic [MW-1:0] q_head_mag;

    assign q_head_cmd = q_head[QW-1:MW];
    assign q_head_mag = q_head[MW-1:0];

    // character front end
    gsfp_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .first_char (first_char),
        .last_char  (last_char),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .push_mag   (q_push_mag),
        .full       (q_full)
    );

    // command queue
    gsfp_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({q_push_cmd, q_push_mag}),
        .pop       (q_pop),
        .pop_data  (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // commit back end
    gsfp_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (!q_empty),
        .q_cmd            (q_head_cmd),
        .q_mag            (q_head_mag),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .utc_time         (utc_time),
        .latitude         (latitude),
        .longitude        (longitude),
        .fix_code         (fix_code),
        .satellites       (satellites),
        .hdop             (hdop),
        .altitude         (altitude),
        .geoid_separation (geoid_separation),
        .dgps_age         (dgps_age),
        .station_id       (station_id)
    );

    // the front end never writes into a full queue
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // a pushed command is still waiting or being taken in the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> !q_empty)
        else $error("pushed command lost from the queue");

    // the kept fix code only ever takes a legal value
    a_fix_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fix_code <= FIX_MAX))
        else $error("fix code out of range on a result word");

endmodule

@@ hw/rtl/gsfp_queue.sv @@
// small register queue between the character front end and the commit back end
module gsfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/gsfp_front.sv @@
// character front end: field counting, digit accumulation and commit classification
module gsfp_front #(
    parameter int VALUE_WIDTH = 40,
    parameter int FRAC_DIGITS = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             ch,
    input  logic                   first_char,
    input  logic                   last_char,
    output logic                   push,
    output gsfp_pkg::cmd_t         push_cmd,
    output logic [VALUE_WIDTH-2:0] push_mag,
    input  logic                   full
);
    import gsfp_pkg::*;

    localparam int MW = VALUE_WIDTH - 1;
    localparam logic [MW-1:0] UTC_LIMIT  = MW'(UTC_MAX);
    localparam logic [MW-1:0] SATS_LIMIT = MW'(SATS_MAX);
    localparam logic [MW-1:0] FIX_LIMIT  = MW'(FIX_MAX);
    localparam logic [FRAC_CNT_W-1:0] FRAC_LIMIT = FRAC_CNT_W'(FRAC_DIGITS);

    typedef struct packed {
        cmt_op_t               op;
        slot_t                 slot;
        logic                  minus;
        logic [FRAC_CNT_W-1:0] scale;
        logic [MW-1:0]         mag;
    } commit_t;

    // turn a finished field into a commit operation
    function automatic commit_t classify(
        input logic [3:0]            idx,
        input logic [MW-1:0]         acc,
        input logic [FRAC_CNT_W-1:0] fc,
        input logic                  minus,
        input logic [7:0]            lead
    );
        commit_t   r;
        slot_map_t sm;
        r  = '0;
        sm = fixed_slot(idx);
        if (sm.hit)
        begin
            r.op    = CMT_FIXED;
            r.slot  = sm.slot;
            r.minus = minus;
            r.scale = FRAC_LIMIT - fc;
            r.mag   = acc;
        end
        else
        begin
            unique case (idx)
                FLD_TIME:
                begin
                    r.op  = CMT_UTC;
                    r.mag = minus ? '0 : ((acc > UTC_LIMIT) ? UTC_LIMIT : acc);
                end
                FLD_NS:
                begin
                    if (lead == CHAR_SOUTH)
                    begin
                        r.op   = CMT_NEGATE;
                        r.slot = SLOT_LAT;
                    end
                end
                FLD_EW:
                begin
                    if (lead == CHAR_WEST)
                    begin
                        r.op   = CMT_NEGATE;
                        r.slot = SLOT_LON;
                    end
                end
                FLD_FIX:
                begin
                    if (acc <= FIX_LIMIT && (!minus || acc == '0))
                    begin
                        r.op  = CMT_FIX;
                        r.mag = acc;
                    end
                end
                FLD_SATS:
                begin
                    r.op  = CMT_SATS;
                    r.mag = minus ? '0 : ((acc > SATS_LIMIT) ? SATS_LIMIT : acc);
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    logic [3:0]            field_index_reg, field_index_next;
    logic [MW-1:0]         accum_reg, accum_next;
    logic [FRAC_CNT_W-1:0] frac_count_reg, frac_count_next;
    logic                  after_point_reg, after_point_next;
    logic                  minus_reg, minus_next;
    logic                  stopped_reg, stopped_next;
    logic [7:0]            lead_char_reg, lead_char_next;

    logic [3:0]            fi0;
    logic [MW-1:0]         acc0, acc1;
    logic [FRAC_CNT_W-1:0] fc0, fc1;
    logic                  ap0, ap1, ms0, ms1, stop0, stop1;
    logic [7:0]            lead0, lead1;
    logic                  live, is_comma, is_digit, lead_empty, accept;
    logic [3:0]            fi_inc;
    logic [MW+3:0]         digit_sum;
    logic [MW-1:0]         acc_sat;
    slot_map_t             cur_map;
    commit_t               ca, cb;
    logic                  commit_a, commit_b;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // field state after a new sentence clear
    always_comb
    begin
        fi0   = first_char ? '0 : field_index_reg;
        acc0  = first_char ? '0 : accum_reg;
        fc0   = first_char ? '0 : frac_count_reg;
        ap0   = first_char ? 1'b0 : after_point_reg;
        ms0   = first_char ? 1'b0 : minus_reg;
        stop0 = first_char ? 1'b0 : stopped_reg;
        lead0 = first_char ? '0 : lead_char_reg;
    end

    // character classification and multiply-by-ten accumulate
    always_comb
    begin
        live       = (fi0 != FLD_IDLE);
        is_comma   = (ch == CHAR_COMMA);
        is_digit   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        lead_empty = (lead0 == '0);
        cur_map    = fixed_slot(fi0);
        fi_inc     = fi0 + 4'd1;
        digit_sum  = ({4'b0, acc0} << 3) + ({4'b0, acc0} << 1) + (MW + 4)'(ch[3:0]);
        acc_sat    = (|digit_sum[MW+3:MW]) ? '1 : digit_sum[MW-1:0];

        acc1  = acc0;
        fc1   = fc0;
        ap1   = ap0;
        ms1   = ms0;
        stop1 = stop0;
        lead1 = lead_empty ? ch : lead0;
        if (!stop0)
        begin
            if (is_digit)
            begin
                if (!ap0)
                begin
                    acc1 = acc_sat;
                end
                else if (fc0 < FRAC_LIMIT)
                begin
                    acc1 = acc_sat;
                    fc1  = fc0 + 1'b1;
                end
            end
            else if (ch == CHAR_POINT && !ap0 && cur_map.hit)
            begin
                ap1 = 1'b1;
            end
            else if ((ch == CHAR_MINUS || ch == CHAR_PLUS) && lead_empty)
            begin
                ms1 = (ch == CHAR_MINUS);
            end
            else
            begin
                stop1 = 1'b1;
            end
        end
    end

    // commit selection and queued command
    always_comb
    begin
        ca = is_comma ? classify(fi0, acc0, fc0, ms0, lead0)
                      : classify(fi0, acc1, fc1, ms1, lead1);
        cb = classify(fi_inc, '0, '0, 1'b0, 8'h00);

        commit_a = live && (is_comma || last_char);
        commit_b = live && is_comma && last_char && (fi_inc != FLD_IDLE);

        push_cmd.clear   = first_char;
        push_cmd.a_op    = commit_a ? ca.op : CMT_NONE;
        push_cmd.a_slot  = ca.slot;
        push_cmd.a_minus = ca.minus;
        push_cmd.a_scale = ca.scale;
        push_cmd.b_op    = commit_b ? cb.op : CMT_NONE;
        push_cmd.b_slot  = cb.slot;
        push_cmd.emit    = last_char;
        push_mag         = ca.mag;

        push = accept && (first_char || last_char || push_cmd.a_op != CMT_NONE
                          || push_cmd.b_op != CMT_NONE);
    end

    // next field state
    always_comb
    begin
        field_index_next = fi0;
        accum_next       = acc0;
        frac_count_next  = fc0;
        after_point_next = ap0;
        minus_next       = ms0;
        stopped_next     = stop0;
        lead_char_next   = lead0;
        if (last_char || (live && is_comma))
        begin
            field_index_next = last_char ? FLD_IDLE : fi_inc;
            accum_next       = '0;
            frac_count_next  = '0;
            after_point_next = 1'b0;
            minus_next       = 1'b0;
            stopped_next     = 1'b0;
            lead_char_next   = '0;
        end
        else if (live)
        begin
            accum_next       = acc1;
            frac_count_next  = fc1;
            after_point_next = ap1;
            minus_next       = ms1;
            stopped_next     = stop1;
            lead_char_next   = lead1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= '0;
            accum_reg       <= '0;
            frac_count_reg  <= '0;
            after_point_reg <= 1'b0;
            minus_reg       <= 1'b0;
            stopped_reg     <= 1'b0;
            lead_char_reg   <= '0;
        end
        else if (accept)
        begin
            field_index_reg <= field_index_next;
            accum_reg       <= accum_next;
            frac_count_reg  <= frac_count_next;
            after_point_reg <= after_point_next;
            minus_reg       <= minus_next;
            stopped_reg     <= stopped_next;
            lead_char_reg   <= lead_char_next;
        end
    end

endmodule

@@ hw/rtl/gsfp_back.sv @@
// commit back end: decimal scaling stages, kept value bank and result register
module gsfp_back #(
    parameter int VALUE_WIDTH = 40,
    parameter int FRAC_DIGITS = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  gsfp_pkg::cmd_t         q_cmd,
    input  logic [VALUE_WIDTH-2:0] q_mag,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [23:0]            utc_time,
    output logic signed [39:0]     latitude,
    output logic signed [39:0]     longitude,
    output logic [2:0]             fix_code,
    output logic [7:0]             satellites,
    output logic signed [39:0]     hdop,
    output logic signed [39:0]     altitude,
    output logic signed [39:0]     geoid_separation,
    output logic signed [39:0]     dgps_age,
    output logic signed [39:0]     station_id
);
    import gsfp_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int MW = VALUE_WIDTH - 1;
    localparam int NS = FRAC_DIGITS + 1;
    localparam int OW = (VALUE_WIDTH < 40) ? VALUE_WIDTH : 40;

    // saturating multiply by ten
    function automatic logic [MW-1:0] times_ten(input logic [MW-1:0] x);
        logic [MW+3:0] t;
        t = ({4'b0, x} << 3) + ({4'b0, x} << 1);
        return (|t[MW+3:MW]) ? '1 : t[MW-1:0];
    endfunction

    logic          stg_valid_reg [NS];
    cmd_t          stg_cmd_reg   [NS];
    logic [MW-1:0] stg_mag_reg   [NS];

    logic [VW-1:0] fixed_reg  [NUM_FIXED];
    logic [VW-1:0] fixed_next [NUM_FIXED];
    logic [23:0]   utc_reg, utc_next;
    logic [7:0]    sats_reg, sats_next;
    logic [2:0]    fix_reg, fix_next;

    logic          out_valid_reg;
    logic [23:0]   out_utc_reg;
    logic [7:0]    out_sats_reg;
    logic [2:0]    out_fix_reg;
    logic [39:0]   out_fixed_reg [NUM_FIXED];

    logic          advance;
    logic          fire_emit;
    cmd_t          tail_cmd;
    logic [MW-1:0] tail_mag;
    logic [VW-1:0] tail_ext;

    assign advance   = !out_valid_reg || out_ready;
    assign q_pop     = advance && q_valid;
    assign tail_cmd  = stg_cmd_reg[NS-1];
    assign tail_mag  = stg_mag_reg[NS-1];
    assign fire_emit = advance && stg_valid_reg[NS-1] && tail_cmd.emit;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                stg_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            stg_valid_reg[0] <= q_valid;
            for (int i = 0; i < FRAC_DIGITS; i++)
            begin
                stg_valid_reg[i+1] <= stg_valid_reg[i];
            end
        end
    end

    // one decimal scaling step per stage after the first
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg_cmd_reg[0] <= q_cmd;
            stg_mag_reg[0] <= q_mag;
            for (int i = 0; i < FRAC_DIGITS; i++)
            begin
                stg_cmd_reg[i+1] <= stg_cmd_reg[i];
                stg_mag_reg[i+1] <= (stg_cmd_reg[i].a_scale > FRAC_CNT_W'(i))
                                    ? times_ten(stg_mag_reg[i]) : stg_mag_reg[i];
            end
        end
    end

    // apply clear, field commit and empty field commit in order
    always_comb
    begin
        fixed_next = fixed_reg;
        utc_next   = utc_reg;
        sats_next  = sats_reg;
        fix_next   = fix_reg;
        tail_ext   = {1'b0, tail_mag};
        if (stg_valid_reg[NS-1])
        begin
            if (tail_cmd.clear)
            begin
                for (int i = 0; i < NUM_FIXED; i++)
                begin
                    fixed_next[i] = '0;
                end
                utc_next  = '0;
                sats_next = '0;
            end
            case (tail_cmd.a_op)
                CMT_FIXED:  fixed_next[tail_cmd.a_slot] = tail_cmd.a_minus ? -tail_ext : tail_ext;
                CMT_UTC:    utc_next = tail_mag[23:0];
                CMT_NEGATE: fixed_next[tail_cmd.a_slot] = -fixed_next[tail_cmd.a_slot];
                CMT_FIX:    fix_next = tail_mag[2:0];
                CMT_SATS:   sats_next = tail_mag[7:0];
                default:
                begin
                end
            endcase
            case (tail_cmd.b_op)
                CMT_FIXED: fixed_next[tail_cmd.b_slot] = '0;
                CMT_UTC:   utc_next = '0;
                CMT_FIX:   fix_next = '0;
                CMT_SATS:  sats_next = '0;
                default:
                begin
                end
            endcase
        end
    end

    // kept values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FIXED; i++)
            begin
                fixed_reg[i] <= '0;
            end
            utc_reg  <= '0;
            sats_reg <= '0;
            fix_reg  <= '0;
        end
        else if (advance)
        begin
            fixed_reg <= fixed_next;
            utc_reg   <= utc_next;
            sats_reg  <= sats_next;
            fix_reg   <= fix_next;
        end
    end

    // result word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stg_valid_reg[NS-1] && tail_cmd.emit;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (fire_emit)
        begin
            out_utc_reg  <= utc_next;
            out_sats_reg <= sats_next;
            out_fix_reg  <= fix_next;
            for (int i = 0; i < NUM_FIXED; i++)
            begin
                out_fixed_reg[i] <= 40'(fixed_next[i][OW-1:0]);
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign utc_time         = out_utc_reg;
    assign satellites       = out_sats_reg;
    assign fix_code         = out_fix_reg;
    assign latitude         = out_fixed_reg[SLOT_LAT];
    assign longitude        = out_fixed_reg[SLOT_LON];
    assign hdop             = out_fixed_reg[SLOT_HDOP];
    assign altitude         = out_fixed_reg[SLOT_ALT];
    assign geoid_separation = out_fixed_reg[SLOT_GEOID];
    assign dgps_age         = out_fixed_reg[SLOT_AGE];
    assign station_id       = out_fixed_reg[SLOT_STATION];

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the gga sentence field parser: sentence stimulus, record prediction, compare
`timescale 1ns / 100ps

module testbench;

    import gsfp_pkg::*;

    localparam int FRAC_DIGITS = 5;
    localparam int VALUE_WIDTH = 40;
    localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
    localparam int HOLD_CYCLES = 400;

    // one character word as offered on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
    } gga_char_t;

    // one parsed position record
    typedef struct packed {
        logic [23:0] utc;
        logic [39:0] lat;
        logic [39:0] lon;
        logic [2:0]  fix;
        logic [7:0]  sats;
        logic [39:0] hdop;
        logic [39:0] alt;
        logic [39:0] geoid;
        logic [39:0] age;
        logic [39:0] station;
    } gga_record_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  ch = 8'h00;
    logic        first_char = 1'b0;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [23:0] utc_time;
    logic signed [39:0] latitude;
    logic signed [39:0] longitude;
    logic [2:0]  fix_code;
    logic [7:0]  satellites;
    logic signed [39:0] hdop;
    logic signed [39:0] altitude;
    logic signed [39:0] geoid_separation;
    logic signed [39:0] dgps_age;
    logic signed [39:0] station_id;

    gga_sentence_field_parser_top #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .ch               (ch),
        .first_char       (first_char),
        .last_char        (last_char),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .utc_time         (utc_time),
        .latitude         (latitude),
        .longitude        (longitude),
        .fix_code         (fix_code),
        .satellites       (satellites),
        .hdop             (hdop),
        .altitude         (altitude),
        .geoid_separation (geoid_separation),
        .dgps_age         (dgps_age),
        .station_id       (station_id)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gga_char_t   pending_words[$];
    gga_record_t fix_records_due[$];
    logic [7:0]  text_buf[$];
    gga_char_t   offer;
    bit          word_taken = 1'b0;
    bit          holding = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          chars_queued = 0;
    int          chars_accepted = 0;
    int          items_made = 0;
    int          records_made = 0;
    int          mismatches = 0;
    event        hold_go;

    // mirror of the parser state
    logic [3:0]         field_num;
    logic [63:0]        mag_acc;
    int                 frac_seen;
    bit                 in_fraction;
    bit                 negative;
    bit                 number_done;
    logic [7:0]         lead_char;
    logic signed [63:0] kept_value [16];
    logic [2:0]         kept_fix;

    function automatic bit is_fixed_field(logic [3:0] idx);
        case (idx)
            FLD_LAT, FLD_LON, FLD_HDOP, FLD_ALT, FLD_GEOID, FLD_AGE, FLD_STATION:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // multiply-by-ten accumulate with saturation
    function automatic logic [63:0] digit_in(logic [63:0] a, logic [63:0] d);
        if (a > (MAG_LIMIT - d) / 64'd10)
            return MAG_LIMIT;
        return a * 64'd10 + d;
    endfunction

    function automatic void clear_field();
        mag_acc = 64'd0;
        frac_seen = 0;
        in_fraction = 1'b0;
        negative = 1'b0;
        number_done = 1'b0;
        lead_char = 8'h00;
    endfunction

    function automatic void reset_parser();
        field_num = 4'd0;
        clear_field();
        foreach (kept_value[i])
            kept_value[i] = 64'sd0;
        kept_fix = 3'd0;
    endfunction

    // one character inside a field; a nul is never kept as the lead character
    function automatic void take_char(logic [7:0] c);
        bit lead;
        lead = (lead_char == 8'h00);
        if (lead)
            lead_char = c;
        if (number_done)
            return;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            if (!in_fraction)
                mag_acc = digit_in(mag_acc, 64'(c - CHAR_ZERO));
            else if (frac_seen < FRAC_DIGITS)
            begin
                mag_acc = digit_in(mag_acc, 64'(c - CHAR_ZERO));
                frac_seen++;
            end
        end
        else if (c == CHAR_POINT && !in_fraction && is_fixed_field(field_num))
            in_fraction = 1'b1;
        else if ((c == CHAR_MINUS || c == CHAR_PLUS) && lead)
            negative = (c == CHAR_MINUS);
        else
            number_done = 1'b1;
    endfunction

    // close the open field into the kept values
    function automatic void commit_field();
        logic [63:0] scale;
        logic [63:0] mag;
        int k;
        if (is_fixed_field(field_num))
        begin
            scale = 64'd1;
            for (k = 0; k < FRAC_DIGITS - frac_seen; k++)
                scale = scale * 64'd10;
            mag = (mag_acc > MAG_LIMIT / scale) ? MAG_LIMIT : mag_acc * scale;
            kept_value[field_num] = negative ? -$signed(mag) : $signed(mag);
            return;
        end
        case (field_num)
            FLD_TIME:
                kept_value[FLD_TIME] = negative ? 64'sd0 :
                    ((mag_acc > UTC_MAX) ? 64'(UTC_MAX) : $signed(mag_acc));
            FLD_NS:
                if (lead_char == CHAR_SOUTH)
                    kept_value[FLD_LAT] = -kept_value[FLD_LAT];
            FLD_EW:
                if (lead_char == CHAR_WEST)
                    kept_value[FLD_LON] = -kept_value[FLD_LON];
            FLD_FIX:
                if (mag_acc <= FIX_MAX && (!negative || mag_acc == 64'd0))
                    kept_fix = mag_acc[2:0];
            FLD_SATS:
                kept_value[FLD_SATS] = negative ? 64'sd0 :
                    ((mag_acc > SATS_MAX) ? 64'(SATS_MAX) : $signed(mag_acc));
            default:
                ;
        endcase
    endfunction

    // predict the effect of one accepted word, queueing a record on the last character
    function automatic void parse_char(logic [7:0] c, logic first, logic last);
        gga_record_t rec;
        if (first)
        begin
            field_num = 4'd0;
            clear_field();
            foreach (kept_value[i])
                kept_value[i] = 64'sd0;
        end
        if (field_num < FLD_IDLE)
        begin
            if (c == CHAR_COMMA)
            begin
                commit_field();
                field_num = field_num + 4'd1;
                clear_field();
            end
            else
                take_char(c);
        end
        if (!last)
            return;
        if (field_num < FLD_IDLE)
            commit_field();
        clear_field();
        field_num = FLD_IDLE;
        rec.utc     = kept_value[FLD_TIME][23:0];
        rec.lat     = kept_value[FLD_LAT][39:0];
        rec.lon     = kept_value[FLD_LON][39:0];
        rec.fix     = kept_fix;
        rec.sats    = kept_value[FLD_SATS][7:0];
        rec.hdop    = kept_value[FLD_HDOP][39:0];
        rec.alt     = kept_value[FLD_ALT][39:0];
        rec.geoid   = kept_value[FLD_GEOID][39:0];
        rec.age     = kept_value[FLD_AGE][39:0];
        rec.station = kept_value[FLD_STATION][39:0];
        fix_records_due.push_back(rec);
    endfunction

    function automatic void check_field(string name, logic [39:0] got, logic [39:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %0s: expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    // input side: count accepted words and predict; output side: compare records
    always @(posedge clk)
    begin
        gga_record_t want;
        word_taken = in_valid && in_ready;
        if (word_taken)
        begin
            parse_char(ch, first_char, last_char);
            chars_accepted++;
        end
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (fix_records_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t record with none due, utc_time %h", $realtime, utc_time);
            end
            else
            begin
                want = fix_records_due.pop_front();
                check_field("utc_time", 40'(utc_time), 40'(want.utc));
                check_field("latitude", latitude, want.lat);
                check_field("longitude", longitude, want.lon);
                check_field("fix_code", 40'(fix_code), 40'(want.fix));
                check_field("satellites", 40'(satellites), 40'(want.sats));
                check_field("hdop", hdop, want.hdop);
                check_field("altitude", altitude, want.alt);
                check_field("geoid_separation", geoid_separation, want.geoid);
                check_field("dgps_age", dgps_age, want.age);
                check_field("station_id", station_id, want.station);
            end
        end
    end

    // driver: offer the next word, idling at random between words
    always @(negedge clk)
    begin
        if (!in_valid || word_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offer = pending_words.pop_front();
                in_valid   <= 1'b1;
                ch         <= offer.ch;
                first_char <= offer.first;
                last_char  <= offer.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    always
    begin
        @(hold_go);
        @(posedge clk);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    // sentence building
    function automatic void add_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    function automatic void add_digits(int n);
        repeat (n) text_buf.push_back(8'(CHAR_ZERO + $urandom_range(9)));
    endfunction

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == CHAR_COMMA) ? 8'h65 : c;
    endfunction

    function automatic void add_number();
        if ($urandom_range(9) == 0)
            return;
        if ($urandom_range(7) == 0)
            text_buf.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
        add_digits(($urandom_range(11) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5));
        if ($urandom_range(2) != 0)
        begin
            text_buf.push_back(CHAR_POINT);
            add_digits(($urandom_range(5) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5));
        end
        // stray character that can stop the number
        if ($urandom_range(11) == 0)
        begin
            case ($urandom_range(5))
                0: text_buf.push_back(CHAR_POINT);
                1: text_buf.push_back(CHAR_MINUS);
                2: text_buf.push_back(CHAR_PLUS);
                3: text_buf.push_back(8'h65);
                4: text_buf.push_back(8'h00);
                default: text_buf.push_back(rand_char());
            endcase
            add_digits($urandom_range(0, 3));
        end
    endfunction

    function automatic void add_hemisphere(string plus_side, string minus_side);
        int r;
        r = $urandom_range(9);
        if (r < 4)
            add_str(plus_side);
        else if (r < 8)
            add_str(minus_side);
        else if (r == 9)
            text_buf.push_back(rand_char());
        if ($urandom_range(7) == 0)
            text_buf.push_back(rand_char());
    endfunction

    function automatic void add_fix();
        int r;
        r = $urandom_range(11);
        if (r <= 4)
            text_buf.push_back(8'(CHAR_ZERO + r));
        else
            case (r)
                5: add_str("-0");
                6: add_str("5");
                7: add_str("9");
                8: ;
                9: add_str("-1");
                10: add_str("+3");
                default: add_number();
            endcase
    endfunction

    function automatic void add_field(int f);
        case (f)
            0: add_str($urandom_range(1) ? "GPGGA" : "GNGGA");
            3: add_hemisphere("N", "S");
            5: add_hemisphere("E", "W");
            6: add_fix();
            10, 12:
                if ($urandom_range(3) != 0)
                    add_str("M");
            default: add_number();
        endcase
    endfunction

    // move the text buffer into the word queue
    function automatic void send_text(bit with_first, bit with_last, bit counted);
        gga_char_t w;
        int i;
        for (i = 0; i < text_buf.size(); i++)
        begin
            w.ch    = text_buf[i];
            w.first = with_first && (i == 0);
            w.last  = with_last && (i == text_buf.size() - 1);
            pending_words.push_back(w);
            chars_queued++;
            if (counted)
                items_made++;
            if (w.last)
                records_made++;
        end
        text_buf.delete();
    endfunction

    function automatic void gen_sentence();
        int n_fields;
        int f;
        bit abandon;
        // short bursts of noise with random marks
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(255)));
            send_text(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
            return;
        end
        if ($urandom_range(9) < 3)
            n_fields = 15;
        else if ($urandom_range(9) == 0)
            n_fields = $urandom_range(16, 18);
        else
            n_fields = $urandom_range(1, 10);
        for (f = 0; f < n_fields; f++)
        begin
            if (f != 0)
                text_buf.push_back(CHAR_COMMA);
            add_field(f);
        end
        if ($urandom_range(9) == 0)
            text_buf.push_back(CHAR_COMMA);
        abandon = ($urandom_range(19) == 0);
        send_text(1'b1, !abandon, 1'b1);
        // checksum tail after the record, ignored by the parser
        if (!abandon && $urandom_range(9) == 0)
        begin
            add_str("*4F");
            send_text(1'b0, 1'b0, 1'b0);
        end
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (chars_accepted != chars_queued || fix_records_due.size() != 0);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        int items_start;
        int records_start;
        @(posedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        items_start = items_made;
        records_start = records_made;
        while (items_made - items_start < 150 || records_made - records_start < 2)
            gen_sentence();
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        reset_parser();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // parsed as though a sentence had begun at reset
        add_str(",7");
        send_text(1'b0, 1'b1, 1'b1);
        // ignored until the next first character
        add_str("x");
        send_text(1'b0, 1'b0, 1'b0);
        // negative time, saturated south latitude
        text_buf.push_back(8'hFF);
        add_str(",-5,99999999,S");
        send_text(1'b1, 1'b1, 1'b1);
        // nul as the only character, first and last together
        text_buf.push_back(8'h00);
        send_text(1'b1, 1'b1, 1'b1);
        // sentence ending on a comma
        add_str("G,");
        send_text(1'b1, 1'b1, 1'b1);
        wait_drained();

        run_phase(0, 0);
        run_phase(83, 0);
        run_phase(0, 83);
        run_phase(26, 26);

        // long receiver hold-off while short sentences keep coming
        @(posedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        -> hold_go;
        repeat (40)
        begin
            add_str("G,");
            add_digits($urandom_range(1, 3));
            send_text(1'b1, 1'b1, 1'b1);
        end
        wait_drained();

        run_phase(0, 0);

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ gga_sentence_field_parser_top.f @@
hw/rtl/gsfp_pkg.sv
hw/rtl/gsfp_queue.sv
hw/rtl/gsfp_front.sv
hw/rtl/gsfp_back.sv
hw/rtl/gga_sentence_field_parser_top.sv
verif/testbench.sv
